### rtl/shc_pkg.sv
// shared types, constants and helper functions for the solid harmonic evaluator
// depends on nothing; every other rtl file refers to it by scoped names
package shc_pkg;

  localparam int MAX_BUILT_DEGREE = 4;
  localparam int DEG_W = 3;
  localparam int SLOT_W = 4;
  localparam int FLAT_W = 6;
  localparam int VAL_W = 64;
  localparam int COORD_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    SRC_Z,
    SRC_X,
    SRC_Y,
    SRC_R2,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_POLD,
    SRC_PNEW,
    SRC_AV,
    SRC_BV,
    SRC_INT,
    SRC_INTQ,
    SRC_NORM
  } src_t;

  typedef enum logic [3:0] {
    DST_R2,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3,
    DST_POLD,
    DST_PNEW,
    DST_AV,
    DST_BV
  } dst_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_31,
    SH_40
  } shift_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    src_t              src_a;
    logic [DEG_W-1:0]  idx_a;
    src_t              src_b;
    logic [DEG_W-1:0]  idx_b;
    dst_t              dst;
    logic [DEG_W-1:0]  idx_d;
    shift_t            shift;
    logic [3:0]        k;
    logic [DEG_W-1:0]  deg;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } stat_t;

  // clamp a sign and magnitude to the signed 64-bit range
  function automatic logic [63:0] sat64(input logic neg, input logic [64:0] mag,
                                        input logic ovf);
    logic [63:0] res;
    if (!neg) begin
      if (ovf || mag > {1'b0, VAL_MAX}) res = VAL_MAX;
      else res = mag[63:0];
    end else begin
      if (ovf || mag >= {1'b0, VAL_MIN}) res = VAL_MIN;
      else res = (~mag[63:0]) + 64'd1;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v) + 64'd1 : v;
  endfunction

  // q0.31 normalisation floor(sqrt(2^63 / ((l+m)!/(l-m)!))), elaboration only
  function automatic logic [31:0] norm_q31(input int l, input int m);
    logic [63:0]  p;
    logic [31:0]  s;
    logic [31:0]  cand;
    logic [127:0] sq;
    p = 64'd1;
    s = '0;
    if (m <= l) begin
      for (int k = l - m + 1; k <= l + m; k++) p = p * 64'(k);
      for (int b = 31; b >= 0; b--) begin
        cand = s | (32'd1 << b);
        sq = 128'(cand) * 128'(cand) * 128'(p);
        if (sq <= (128'd1 << 63)) s = cand;
      end
    end
    return s;
  endfunction

endpackage

### rtl/solid_harmonic_evaluator_core.sv
// top level of the solid harmonic evaluator: configuration register, controller and datapath
// depends on shc_pkg, shc_ctrl and shc_dp
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   z_coord, x_coord, y_coord (q3.28)
//  output    out        out_valid / out_stall harmonic_value (q23.40), degree, slot,
//                                             flat_index, last_of_point
//  config    in         apb write, pready=1   max_degree at byte address 0
//
// one point at a time: the controller issues one command to the datapath and waits for it;
// each multiply passes through the shared 32 x 32 multiplier in four partial products
// in_stall is high from acceptance of a point until its last result sits in the output
// register; a stalled output holds the register and the controller waits on it
// synchronous active-high reset; max_degree resets to 2, a degree of 1 or less gives no results
module solid_harmonic_evaluator_core #(
  parameter int MAX_BUILT_DEGREE = shc_pkg::MAX_BUILT_DEGREE
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [shc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [shc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // input transaction
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             z_coord,
  input  logic signed [31:0]             x_coord,
  input  logic signed [31:0]             y_coord,
  // output transaction
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [63:0]             harmonic_value,
  output logic [shc_pkg::DEG_W-1:0]      degree,
  output logic [shc_pkg::SLOT_W-1:0]     slot,
  output logic [shc_pkg::FLAT_W-1:0]     flat_index,
  output logic                           last_of_point
);

  logic [shc_pkg::DEG_W-1:0] max_degree;
  logic                      in_accept;
  shc_pkg::cmd_t             cmd;
  shc_pkg::stat_t            stat;

  assign pready    = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // register 0 at byte address 0; other word addresses ignore writes and read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      max_degree <= 3'd2;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      max_degree <= pwdata[2:0];
    end
  end

  assign prdata = paddr[2] ? '0 : {29'd0, max_degree};

  shc_ctrl #(
    .MB (MAX_BUILT_DEGREE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .max_degree (max_degree),
    .stat       (stat),
    .cmd        (cmd)
  );

  // coordinates are taken straight into the datapath on the accepting edge
  shc_dp #(
    .MB (MAX_BUILT_DEGREE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .load           (in_accept),
    .z_in           (z_coord),
    .x_in           (x_coord),
    .y_in           (y_coord),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .harmonic_value (harmonic_value),
    .degree         (degree),
    .slot           (slot),
    .flat_index     (flat_index),
    .last_of_point  (last_of_point)
  );

endmodule

### rtl/shc_mul.sv
// shared 64 x 64 multiplier: four 32 x 32 partial products, round, shift, saturate
// depends on shc_pkg
module shc_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  input  shc_pkg::shift_t     shift,
  output logic                done,
  output logic [63:0]         result
);

  logic [63:0]     ma;
  logic [63:0]     mb;
  logic            neg;
  shc_pkg::shift_t sh;
  logic [127:0]    acc;
  logic [63:0]     pp;
  logic [1:0]      pp_pos;
  logic [2:0]      step;
  logic            busy;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;
  logic [127:0] shifted;
  logic [63:0]  fin_mag;
  logic         fin_ovf;
  logic [127:0] round_c;

  always_comb begin
    a_half = step[1] ? ma[63:32] : ma[31:0];
    b_half = step[0] ? mb[63:32] : mb[31:0];
    case (pp_pos)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
    case (sh)
      shc_pkg::SH_40: shifted = acc >> 40;
      shc_pkg::SH_31: shifted = acc >> 31;
      default:        shifted = acc;
    endcase
    fin_mag = shifted[63:0];
    fin_ovf = |shifted[127:64];
    case (shift)
      shc_pkg::SH_40: round_c = 128'd1 << 39;
      shc_pkg::SH_31: round_c = 128'd1 << 30;
      default:        round_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        ma   <= shc_pkg::mag64(a);
        mb   <= shc_pkg::mag64(b);
        neg  <= a[63] ^ b[63];
        sh   <= shift;
        acc  <= round_c;
      end else if (busy) begin
        if (step <= 3'd3) begin
          pp     <= a_half * b_half;
          pp_pos <= {1'b0, step[0]} + {1'b0, step[1]};
        end
        if (step >= 3'd1 && step <= 3'd4) acc <= acc + pp_shifted;
        if (step == 3'd5) begin
          result <= shc_pkg::sat64(neg && (fin_mag != 64'd0), {1'b0, fin_mag}, fin_ovf);
          done   <= 1'b1;
          busy   <= 1'b0;
        end
        step <= step + 3'd1;
      end
    end
  end

endmodule

### rtl/shc_div.sv
// divider by a small positive integer through a reciprocal table, sixteen quotient bits a cycle,
// rounded half away from zero; depends on shc_pkg
module shc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [2:0]  d,
  output logic        done,
  output logic [63:0] result
);

  logic [79:0] dvd;
  logic [79:0] quo;
  logic [2:0]  rem;
  logic [2:0]  dsr;
  logic [22:0] recip;
  logic        neg_a;
  logic [2:0]  cnt;
  logic        busy;

  logic [18:0] v;
  logic [41:0] prod;
  logic [15:0] qd;
  logic [18:0] back;
  logic [2:0]  rem_c;
  logic [79:0] quo_c;
  logic [64:0] num;

  // ceil(2^22 / d), exact for a remainder and a sixteen bit digit
  function automatic logic [22:0] recip_of(input logic [2:0] dv);
    logic [22:0] r;
    case (dv)
      3'd1:    r = 23'd4194304;
      3'd2:    r = 23'd2097152;
      3'd3:    r = 23'd1398102;
      3'd4:    r = 23'd1048576;
      3'd5:    r = 23'd838861;
      3'd6:    r = 23'd699051;
      3'd7:    r = 23'd599187;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    v     = {rem, dvd[79:64]};
    prod  = 42'(v) * 42'(recip);
    qd    = prod[37:22];
    back  = 19'(qd) * 19'(dsr);
    rem_c = 3'(v - back);
    quo_c = {quo[63:0], qd};
    num   = {1'b0, shc_pkg::mag64(a)} + 65'(d >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        dvd   <= {15'd0, num};
        quo   <= '0;
        rem   <= '0;
        dsr   <= d;
        recip <= recip_of(d);
        neg_a <= a[63];
      end else if (busy) begin
        dvd <= {dvd[63:0], 16'd0};
        quo <= quo_c;
        rem <= rem_c;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          result <= shc_pkg::sat64(neg_a && (quo_c != 80'd0), quo_c[64:0], 1'b0);
          done   <= 1'b1;
          busy   <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/shc_dp.sv
// datapath: value registers, operand selection, adder, multiplier and divider, output register
// depends on shc_pkg, shc_mul and shc_div
module shc_dp #(
  parameter int MB = shc_pkg::MAX_BUILT_DEGREE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  shc_pkg::cmd_t               cmd,
  output shc_pkg::stat_t              stat,
  input  logic                        load,
  input  logic signed [31:0]          z_in,
  input  logic signed [31:0]          x_in,
  input  logic signed [31:0]          y_in,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic signed [63:0]          harmonic_value,
  output logic [shc_pkg::DEG_W-1:0]   degree,
  output logic [shc_pkg::SLOT_W-1:0]  slot,
  output logic [shc_pkg::FLAT_W-1:0]  flat_index,
  output logic                        last_of_point
);

  localparam int N = MB + 1;
  localparam int IDXW = $clog2(N);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EXEC,
    PH_WAIT
  } phase_t;

  phase_t        phase;
  shc_pkg::cmd_t cmd_q;
  logic          done;

  logic [63:0] z, x, y, r2, t0, t1, t2, t3;
  logic [63:0] pold [N];
  logic [63:0] pnew [N];
  logic [63:0] av [N];
  logic [63:0] bv [N];
  logic [31:0] norm_tab [N][N];

  for (genvar gl = 0; gl < N; gl++) begin : g_norm_l
    for (genvar gm = 0; gm < N; gm++) begin : g_norm_m
      assign norm_tab[gl][gm] = shc_pkg::norm_q31(gl, gm);
    end
  end

  logic [63:0] opa, opb;
  logic [64:0] sum65, dif65;
  logic [63:0] add_sat, sub_sat;
  logic        wb_en;
  logic [63:0] wb_val;
  logic        mul_start, div_start, mul_done, div_done;
  logic [63:0] mul_res, div_res;
  logic        emit_go;

  function automatic logic [63:0] pick(input shc_pkg::src_t s, input logic [IDXW-1:0] i,
                                       input logic [3:0] k, input logic [IDXW-1:0] dg);
    logic [63:0] v;
    case (s)
      shc_pkg::SRC_Z:    v = z;
      shc_pkg::SRC_X:    v = x;
      shc_pkg::SRC_Y:    v = y;
      shc_pkg::SRC_R2:   v = r2;
      shc_pkg::SRC_T0:   v = t0;
      shc_pkg::SRC_T1:   v = t1;
      shc_pkg::SRC_T2:   v = t2;
      shc_pkg::SRC_T3:   v = t3;
      shc_pkg::SRC_POLD: v = pold[i];
      shc_pkg::SRC_PNEW: v = pnew[i];
      shc_pkg::SRC_AV:   v = av[i];
      shc_pkg::SRC_BV:   v = bv[i];
      shc_pkg::SRC_INT:  v = {60'd0, k};
      shc_pkg::SRC_INTQ: v = {20'd0, k, 40'd0};
      shc_pkg::SRC_NORM: v = {32'd0, norm_tab[dg][i]};
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(cmd_q.src_a, cmd_q.idx_a[IDXW-1:0], cmd_q.k, cmd_q.deg[IDXW-1:0]);
    opb = pick(cmd_q.src_b, cmd_q.idx_b[IDXW-1:0], cmd_q.k, cmd_q.deg[IDXW-1:0]);
    sum65 = {opa[63], opa} + {opb[63], opb};
    dif65 = {opa[63], opa} - {opb[63], opb};
    if (sum65[64] != sum65[63]) add_sat = sum65[64] ? shc_pkg::VAL_MIN : shc_pkg::VAL_MAX;
    else add_sat = sum65[63:0];
    if (dif65[64] != dif65[63]) sub_sat = dif65[64] ? shc_pkg::VAL_MIN : shc_pkg::VAL_MAX;
    else sub_sat = dif65[63:0];

    wb_en     = 1'b0;
    wb_val    = opa;
    mul_start = 1'b0;
    div_start = 1'b0;
    emit_go   = 1'b0;
    case (phase)
      PH_EXEC: begin
        case (cmd_q.op)
          shc_pkg::OP_MOV: wb_en = 1'b1;
          shc_pkg::OP_ADD: begin
            wb_en  = 1'b1;
            wb_val = add_sat;
          end
          shc_pkg::OP_SUB: begin
            wb_en  = 1'b1;
            wb_val = sub_sat;
          end
          shc_pkg::OP_MUL:  mul_start = 1'b1;
          shc_pkg::OP_DIV:  div_start = 1'b1;
          shc_pkg::OP_EMIT: emit_go = !out_valid || !out_stall;
          default: ;
        endcase
      end
      PH_WAIT: begin
        if (cmd_q.op == shc_pkg::OP_MUL) begin
          wb_en  = mul_done;
          wb_val = mul_res;
        end else begin
          wb_en  = div_done;
          wb_val = div_res;
        end
      end
      default: ;
    endcase
  end

  shc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (opa),
    .b      (opb),
    .shift  (cmd_q.shift),
    .done   (mul_done),
    .result (mul_res)
  );

  shc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .a      (opa),
    .d      (cmd_q.k[2:0]),
    .done   (div_done),
    .result (div_res)
  );

  // sequencing of one command
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (cmd.start) begin
            cmd_q <= cmd;
            phase <= PH_EXEC;
          end
        end
        PH_EXEC: begin
          if (mul_start || div_start) begin
            phase <= PH_WAIT;
          end else if (cmd_q.op != shc_pkg::OP_EMIT || emit_go) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end
        end
        PH_WAIT: begin
          if (wb_en) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.busy = (phase != PH_IDLE);

  // value registers
  always_ff @(posedge clk) begin
    if (load) begin
      z       <= {{20{z_in[31]}}, z_in, 12'd0};
      x       <= {{20{x_in[31]}}, x_in, 12'd0};
      y       <= {{20{y_in[31]}}, y_in, 12'd0};
      pold[0] <= shc_pkg::ONE_Q40;
      pnew[0] <= {{20{z_in[31]}}, z_in, 12'd0};
      pnew[1] <= shc_pkg::ONE_Q40;
      av[1]   <= {{20{x_in[31]}}, x_in, 12'd0};
      bv[1]   <= {{20{y_in[31]}}, y_in, 12'd0};
    end else if (wb_en) begin
      case (cmd_q.dst)
        shc_pkg::DST_R2:   r2 <= wb_val;
        shc_pkg::DST_T0:   t0 <= wb_val;
        shc_pkg::DST_T1:   t1 <= wb_val;
        shc_pkg::DST_T2:   t2 <= wb_val;
        shc_pkg::DST_T3:   t3 <= wb_val;
        shc_pkg::DST_POLD: pold[cmd_q.idx_d[IDXW-1:0]] <= wb_val;
        shc_pkg::DST_PNEW: pnew[cmd_q.idx_d[IDXW-1:0]] <= wb_val;
        shc_pkg::DST_AV:   av[cmd_q.idx_d[IDXW-1:0]] <= wb_val;
        shc_pkg::DST_BV:   bv[cmd_q.idx_d[IDXW-1:0]] <= wb_val;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid      <= 1'b1;
      harmonic_value <= opa;
      degree         <= cmd_q.deg;
      slot           <= cmd_q.slot;
      flat_index     <= 6'(cmd_q.deg) * 6'(cmd_q.deg) - 6'd1 + 6'(cmd_q.slot);
      last_of_point  <= cmd_q.last;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/shc_ctrl.sv
// controller: walks the recurrence over degree, order and slot, one command at a time
// depends on shc_pkg
module shc_ctrl #(
  parameter int MB = shc_pkg::MAX_BUILT_DEGREE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [shc_pkg::DEG_W-1:0]  max_degree,
  input  shc_pkg::stat_t             stat,
  output shc_pkg::cmd_t              cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_R20, S_R21, S_R22, S_R23, S_R24,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_Q7, S_Q8, S_Q9,
    S_E0, S_E1, S_E2, S_E3
  } state_t;

  localparam logic [2:0] MB_D = 3'(MB);

  state_t     state;
  logic       wait_q;
  logic [2:0] l, m, top;
  logic [3:0] slot;

  logic [2:0] top_c, mm, lm1;
  logic [3:0] f, lpm1, two_l;

  always_comb begin
    top_c = (max_degree < MB_D) ? max_degree : MB_D;
    mm    = 3'((5'(slot) + 5'd1) >> 1);
    lm1   = l - 3'd1;
    f     = {l, 1'b0} - 4'd1;
    lpm1  = {1'b0, l} + {1'b0, m} - 4'd1;
    two_l = {l, 1'b0};
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.start = (state != S_IDLE) && !wait_q;
    cmd.deg   = l;
    cmd.slot  = slot;
    case (state)
      S_R20: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_X; cmd.src_b = shc_pkg::SRC_X;
        cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_40;
      end
      S_R21: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_Y; cmd.src_b = shc_pkg::SRC_Y;
        cmd.dst = shc_pkg::DST_T1; cmd.shift = shc_pkg::SH_40;
      end
      S_R22: begin
        cmd.op = shc_pkg::OP_ADD; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_T1;
        cmd.dst = shc_pkg::DST_T0;
      end
      S_R23: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_Z; cmd.src_b = shc_pkg::SRC_Z;
        cmd.dst = shc_pkg::DST_T1; cmd.shift = shc_pkg::SH_40;
      end
      S_R24: begin
        cmd.op = shc_pkg::OP_ADD; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_T1;
        cmd.dst = shc_pkg::DST_R2;
      end
      // one order of the legendre-like recurrence
      S_P0: begin
        cmd.op = shc_pkg::OP_MOV; cmd.src_a = shc_pkg::SRC_POLD; cmd.idx_a = m;
        cmd.dst = shc_pkg::DST_T2;
      end
      S_P1: begin
        cmd.op = shc_pkg::OP_MOV; cmd.src_a = shc_pkg::SRC_PNEW; cmd.idx_a = m;
        cmd.dst = shc_pkg::DST_POLD; cmd.idx_d = m;
      end
      S_P2: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_Z; cmd.src_b = shc_pkg::SRC_POLD;
        cmd.idx_b = m; cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_40;
      end
      S_P3: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_INT;
        cmd.k = f; cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_0;
      end
      S_P4: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_R2; cmd.src_b = shc_pkg::SRC_T2;
        cmd.dst = shc_pkg::DST_T1; cmd.shift = shc_pkg::SH_40;
      end
      S_P5: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_T1; cmd.src_b = shc_pkg::SRC_INT;
        cmd.k = lpm1; cmd.dst = shc_pkg::DST_T1; cmd.shift = shc_pkg::SH_0;
      end
      S_P6: begin
        cmd.op = shc_pkg::OP_SUB; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_T1;
        cmd.dst = shc_pkg::DST_T0;
      end
      S_P7: begin
        cmd.op = shc_pkg::OP_DIV; cmd.src_a = shc_pkg::SRC_T0; cmd.k = {1'b0, l - m};
        cmd.dst = shc_pkg::DST_PNEW; cmd.idx_d = m;
      end
      // top two orders and the azimuthal pair
      S_Q0: begin
        cmd.op = shc_pkg::OP_MOV; cmd.src_a = shc_pkg::SRC_PNEW; cmd.idx_a = lm1;
        cmd.dst = shc_pkg::DST_POLD; cmd.idx_d = lm1;
      end
      S_Q1: begin
        cmd.op = shc_pkg::OP_MOV; cmd.src_a = shc_pkg::SRC_INTQ; cmd.k = f;
        cmd.dst = shc_pkg::DST_PNEW; cmd.idx_d = l;
      end
      S_Q2: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_Z; cmd.src_b = shc_pkg::SRC_PNEW;
        cmd.idx_b = l; cmd.dst = shc_pkg::DST_PNEW; cmd.idx_d = lm1;
        cmd.shift = shc_pkg::SH_40;
      end
      S_Q3: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_X; cmd.src_b = shc_pkg::SRC_AV;
        cmd.idx_b = lm1; cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_40;
      end
      S_Q4: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_Y; cmd.src_b = shc_pkg::SRC_BV;
        cmd.idx_b = lm1; cmd.dst = shc_pkg::DST_T1; cmd.shift = shc_pkg::SH_40;
      end
      S_Q5: begin
        cmd.op = shc_pkg::OP_SUB; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_T1;
        cmd.dst = shc_pkg::DST_T3;
      end
      S_Q6: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_X; cmd.src_b = shc_pkg::SRC_BV;
        cmd.idx_b = lm1; cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_40;
      end
      S_Q7: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_Y; cmd.src_b = shc_pkg::SRC_AV;
        cmd.idx_b = lm1; cmd.dst = shc_pkg::DST_T1; cmd.shift = shc_pkg::SH_40;
      end
      S_Q8: begin
        cmd.op = shc_pkg::OP_ADD; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_T1;
        cmd.dst = shc_pkg::DST_BV; cmd.idx_d = l;
      end
      S_Q9: begin
        cmd.op = shc_pkg::OP_MOV; cmd.src_a = shc_pkg::SRC_T3;
        cmd.dst = shc_pkg::DST_AV; cmd.idx_d = l;
      end
      // shell output
      S_E0: begin
        cmd.op = shc_pkg::OP_EMIT; cmd.src_a = shc_pkg::SRC_PNEW; cmd.idx_a = 3'd0;
      end
      S_E1: begin
        cmd.op    = shc_pkg::OP_MUL;
        cmd.src_a = slot[0] ? shc_pkg::SRC_AV : shc_pkg::SRC_BV;
        cmd.idx_a = mm; cmd.src_b = shc_pkg::SRC_PNEW; cmd.idx_b = mm;
        cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_40;
      end
      S_E2: begin
        cmd.op = shc_pkg::OP_MUL; cmd.src_a = shc_pkg::SRC_T0; cmd.src_b = shc_pkg::SRC_NORM;
        cmd.idx_b = mm; cmd.dst = shc_pkg::DST_T0; cmd.shift = shc_pkg::SH_31;
      end
      S_E3: begin
        cmd.op = shc_pkg::OP_EMIT; cmd.src_a = shc_pkg::SRC_T0;
        cmd.last = (l == top) && (slot == two_l);
      end
      default: cmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wait_q <= 1'b0;
      l      <= 3'd2;
      m      <= '0;
      top    <= '0;
      slot   <= '0;
    end else begin
      if (state == S_IDLE) begin
        wait_q <= 1'b0;
        if (in_valid) begin
          top <= top_c;
          l   <= 3'd2;
          m   <= '0;
          if (top_c >= 3'd2) state <= S_R20;
        end
      end else if (!wait_q) begin
        wait_q <= 1'b1;
      end else if (stat.done) begin
        wait_q <= 1'b0;
        case (state)
          S_R20: state <= S_R21;
          S_R21: state <= S_R22;
          S_R22: state <= S_R23;
          S_R23: state <= S_R24;
          S_R24: state <= S_P0;
          S_P0:  state <= S_P1;
          S_P1:  state <= S_P2;
          S_P2:  state <= S_P3;
          S_P3:  state <= S_P4;
          S_P4:  state <= S_P5;
          S_P5:  state <= S_P6;
          S_P6:  state <= S_P7;
          S_P7: begin
            if ({1'b0, m} + 4'd3 <= {1'b0, l}) begin
              m     <= m + 3'd1;
              state <= S_P0;
            end else begin
              state <= S_Q0;
            end
          end
          S_Q0: state <= S_Q1;
          S_Q1: state <= S_Q2;
          S_Q2: state <= S_Q3;
          S_Q3: state <= S_Q4;
          S_Q4: state <= S_Q5;
          S_Q5: state <= S_Q6;
          S_Q6: state <= S_Q7;
          S_Q7: state <= S_Q8;
          S_Q8: state <= S_Q9;
          S_Q9: begin
            slot  <= '0;
            state <= S_E0;
          end
          S_E0: begin
            slot  <= 4'd1;
            state <= S_E1;
          end
          S_E1: state <= S_E2;
          S_E2: state <= S_E3;
          S_E3: begin
            if (slot == two_l) begin
              if (l == top) begin
                state <= S_IDLE;
              end else begin
                l     <= l + 3'd1;
                m     <= '0;
                state <= S_P0;
              end
            end else begin
              slot  <= slot + 4'd1;
              state <= S_E1;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

### bench/tb_solid_harmonic_evaluator_core.sv
// self-checking bench for solid_harmonic_evaluator_core: points in, harmonic transactions out
// depends on shc_pkg and the rtl of the block; holds its own fixed-point predictor
// and a scoreboard class, and reads no files
module tb_solid_harmonic_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int SETTLE = 1200;        // settle time, sized for a point at the top degree
  localparam logic [shc_pkg::CFG_ADDR_W-1:0] ADDR_MAX_DEGREE = 3'd0;
  localparam logic [shc_pkg::CFG_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  deg;
    logic [3:0]  slot;
    logic [5:0]  flat;
    logic        last;
  } harmonic_t;

  // clamp a sign and wide magnitude to the signed 64-bit range
  function automatic longint clamp64(bit neg, logic [127:0] mag);
    if (!neg) return (mag > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag[63:0];
    if (mag >= 128'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return -longint'(mag[63:0]);
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // (a*b) >> s with rounding half away from zero; a zero low word drops the sign
  function automatic longint fx_mul(longint a, longint b, int s);
    bit neg;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
    if (p[63:0] == 64'd0) neg = 0;
    return clamp64(neg, p);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic longint fx_div(longint a, int d);
    logic [127:0] q;
    q = ({64'd0, abs64(a)} + 128'(d / 2)) / 128'(d);
    return clamp64(a < 0 && q != 0, q);
  endfunction

  // q0.31 factor sqrt(2 (l-m)!/(l+m)!) found bit by bit
  function automatic longint shell_norm(int l, int m);
    logic [63:0] p, n, r;
    logic [127:0] c;
    p = 1;
    for (int k = l - m + 1; k <= l + m; k++) p = p * 64'(k);
    n = (64'd1 << 63) / p;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = 128'(r | (64'd1 << b));
      if (c * c <= 128'(n)) r = c[63:0];
    end
    return longint'(r);
  endfunction

  class harmonic_scoreboard;
    harmonic_t  awaited[$];
    int unsigned max_degree;
    int         errors, points, results;

    function new();
      max_degree = 2;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // expected harmonics of one accepted point
    function void note_point(logic [31:0] zc, logic [31:0] xc, logic [31:0] yc);
      longint z, x, y, r2, prev, num, v, az;
      longint pold[8], pnew[8], av[8], bv[8];
      int top, f, mm;
      harmonic_t h;
      points++;
      top = max_degree < shc_pkg::MAX_BUILT_DEGREE ? max_degree : shc_pkg::MAX_BUILT_DEGREE;
      if (top <= 1) return;
      z = longint'(signed'(zc)) * 4096;
      x = longint'(signed'(xc)) * 4096;
      y = longint'(signed'(yc)) * 4096;
      r2 = fx_add(fx_add(fx_mul(x, x, 40), fx_mul(y, y, 40)), fx_mul(z, z, 40));
      for (int i = 0; i < 8; i++) begin
        pold[i] = 0; pnew[i] = 0; av[i] = 0; bv[i] = 0;
      end
      pold[0] = longint'(shc_pkg::ONE_Q40);
      pnew[0] = z;
      pnew[1] = longint'(shc_pkg::ONE_Q40);
      av[1] = x;
      bv[1] = y;
      for (int l = 2; l <= top; l++) begin
        f = 2 * l - 1;
        for (int m = 0; m + 2 <= l; m++) begin
          prev = pold[m];
          pold[m] = pnew[m];
          num = fx_sub(fx_mul(fx_mul(z, pold[m], 40), f, 0),
                       fx_mul(fx_mul(r2, prev, 40), l + m - 1, 0));
          pnew[m] = fx_div(num, l - m);
        end
        pold[l-1] = pnew[l-1];
        pnew[l] = longint'(f) * longint'(shc_pkg::ONE_Q40);
        pnew[l-1] = fx_mul(z, pnew[l], 40);
        av[l] = fx_sub(fx_mul(x, av[l-1], 40), fx_mul(y, bv[l-1], 40));
        bv[l] = fx_add(fx_mul(x, bv[l-1], 40), fx_mul(y, av[l-1], 40));
        for (int s = 0; s <= 2 * l; s++) begin
          if (s == 0) begin
            v = pnew[0];
          end else begin
            mm = (s + 1) / 2;
            az = (s % 2) ? av[mm] : bv[mm];
            v = fx_mul(fx_mul(az, pnew[mm], 40), shell_norm(l, mm), 31);
          end
          h.value = v;
          h.deg = 3'(l);
          h.slot = 4'(s);
          h.flat = 6'(l * l - 1 + s);
          h.last = (l == top && s == 2 * l);
          awaited.push_back(h);
        end
      end
    endfunction

    function void check(harmonic_t got);
      harmonic_t e;
      results++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result value %h deg %0d slot %0d",
                         got.value, got.deg, got.slot));
        return;
      end
      e = awaited.pop_front();
      if (got.value !== e.value)
        report($sformatf("deg %0d slot %0d value %h, wanted %h", e.deg, e.slot,
                         got.value, e.value));
      if (got.deg !== e.deg) report($sformatf("degree %0d, wanted %0d", got.deg, e.deg));
      if (got.slot !== e.slot) report($sformatf("slot %0d, wanted %0d", got.slot, e.slot));
      if (got.flat !== e.flat)
        report($sformatf("flat_index %0d, wanted %0d", got.flat, e.flat));
      if (got.last !== e.last)
        report($sformatf("last_of_point %b, wanted %b (deg %0d slot %0d)", got.last, e.last,
                         e.deg, e.slot));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [shc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [shc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [shc_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic signed [31:0] z_coord = '0, x_coord = '0, y_coord = '0;
  logic out_valid, out_stall = 0;
  logic signed [63:0] harmonic_value;
  logic [shc_pkg::DEG_W-1:0] degree;
  logic [shc_pkg::SLOT_W-1:0] slot;
  logic [shc_pkg::FLAT_W-1:0] flat_index;
  logic last_of_point;

  harmonic_scoreboard sb = new();
  int idle_pct = 0;      // chance per cycle that the sender offers nothing
  int stall_pct = 0;     // chance per cycle that the receiver stalls
  bit hold_req = 0;
  int hold_left = 0;
  int quiet = 0;

  solid_harmonic_evaluator_core i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .z_coord, .x_coord, .y_coord,
    .out_valid, .out_stall, .harmonic_value, .degree, .slot, .flat_index, .last_of_point
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver: random stalls, or a long hold-off on request so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor and watchdog on quiet stretches
  always @(posedge clk) begin
    harmonic_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.value = harmonic_value;
        got.deg = degree;
        got.slot = slot;
        got.flat = flat_index;
        got.last = last_of_point;
        sb.check(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // apb write; the register takes the value at the access edge, then the bus is left idle
  task automatic cfg_write(logic [shc_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_MAX_DEGREE) sb.max_degree = data[2:0];
    @(posedge clk);
  endtask

  task automatic cfg_read_check();
    psel <= 1; penable <= 0; pwrite <= 0; paddr <= ADDR_MAX_DEGREE;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata !== 32'(sb.max_degree))
      sb.report($sformatf("max_degree read %h, wanted %0d", prdata, sb.max_degree));
    psel <= 0; penable <= 0;
  endtask

  // offer one point and hold it until the block takes it
  task automatic send_point(logic [31:0] zc, logic [31:0] xc, logic [31:0] yc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    z_coord <= zc; x_coord <= xc; y_coord <= yc;
    do @(posedge clk); while (in_stall);
    sb.note_point(zc, xc, yc);
  endtask

  // sender pauses until every awaited result is in, then lets the block settle
  task automatic drain(int extra);
    in_valid <= 0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    int kind;
    kind = $urandom_range(99);
    if (kind < 45) return $urandom;
    if (kind < 75) return 32'(signed'($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000);
    if (kind < 85) return 32'(signed'($urandom_range(32'h1FFF_FFF)) - 32'sh100_0000);
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h1000_0000;  // exactly one
      3: return 32'hF000_0000;  // minus one
      default: return 32'h0;
    endcase
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic new_phase(int degree_value, int idle, int stall);
    drain(SETTLE);
    // junk in the upper bits must be dropped
    cfg_write(ADDR_MAX_DEGREE, {$urandom_range(32'h1FFF_FFFF), 3'(degree_value)});
    cfg_read_check();
    idle_pct = idle;
    stall_pct = stall;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    cfg_read_check();

    // directed points at the reset degree: zero, extremes, unit axes, minus ones, tiny and alternating values
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h1000_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'h1000_0000, 32'h0);
    send_point(32'h0, 32'h0, 32'h1000_0000);
    send_point(32'hF000_0000, 32'hF000_0000, 32'hF000_0000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

    // the unused register address must leave the degree alone
    drain(SETTLE);
    cfg_write(ADDR_UNUSED, 32'h7);
    cfg_read_check();
    // top degree: overflow and saturation cases at full range, then random points
    new_phase(4, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0, 32'h8000_0000, 32'h0);
    send_point(32'h4000_0000, 32'h0, 32'hC000_0000);
    random_points(96);

    // requested degree above the built limit is clamped
    new_phase(7, 52, 0);
    random_points(90);

    // receiver stalls, then a long hold-off while points keep coming
    new_phase(3, 0, 52);
    random_points(30);
    hold_req = 1;
    random_points(50);

    // degrees that produce nothing
    new_phase(0, 22, 22);
    random_points(20);
    new_phase(1, 22, 22);
    random_points(20);

    new_phase(4, 22, 22);
    random_points(60);
    hold_req = 1;
    random_points(40);

    new_phase(2, 0, 0);
    random_points(60);

    drain(100);
    $display("covered %0d points over degree settings 0 to 7, %0d harmonics checked",
             sb.points, sb.results);
    $display("phases without idling, with sender gaps, receiver stalls, both, and hold-offs");
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### solid_harmonic_evaluator_core.f
rtl/shc_pkg.sv
rtl/shc_mul.sv
rtl/shc_div.sv
rtl/shc_dp.sv
rtl/shc_ctrl.sv
rtl/solid_harmonic_evaluator_core.sv
bench/tb_solid_harmonic_evaluator_core.sv
